/* rtl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and controller/datapath interface types for the status
// frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int INFO_BYTES_DEF = 15;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 4;
    localparam int CODE_W  = 2;

    localparam logic [BYTE_W-1:0] START_BYTE     = 8'd1;
    localparam logic [BYTE_W-1:0] STOP_BYTE      = 8'd4;
    localparam int                FRAME_OVERHEAD = 5;
    localparam logic [BYTE_W-1:0] ADDRESS_RESET  = 8'd255;

    localparam logic [CODE_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [CODE_W-1:0] ERR_BAD_ADDR = 2'd1;
    localparam logic [CODE_W-1:0] ERR_BAD_LEN  = 2'd2;
    localparam logic [CODE_W-1:0] ERR_BAD_STOP = 2'd3;

    typedef struct packed {
        logic               store_ctrl;
        logic               store_info;
        logic               load_out;
        logic               out_ok;
        logic [CODE_W-1:0]  out_code;
        logic               out_use_ctrl;
        logic               out_from_store;
        logic               out_last;
        logic [INDEX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic start_match;
        logic addr_match;
        logic len_match;
        logic stop_match;
        logic out_stall;
    } t_dp_status;

endpackage

/* rtl/sfr_datapath.sv */
// ----------------------------------------------------------------------------
// sfr_datapath
// Address register, control byte and information byte store, byte compares
// and the result output register.
// ----------------------------------------------------------------------------
module sfr_datapath
    import sfr_pkg::*;
#(
    parameter int INFO_BYTES = INFO_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [BYTE_W-1:0]  i_cfg_wdata,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_frame_ok,
    output logic [CODE_W-1:0]  o_error_code,
    output logic [BYTE_W-1:0]  o_control_byte,
    output logic [INDEX_W-1:0] o_field_index,
    output logic [BYTE_W-1:0]  o_field_value,
    output logic               o_last
);

    localparam int ADDR_W = (INFO_BYTES > 1) ? $clog2(INFO_BYTES) : 1;
    localparam logic [BYTE_W-1:0] LEN_BYTE = BYTE_W'(INFO_BYTES + FRAME_OVERHEAD);

    logic [BYTE_W-1:0]  r_dev_addr;
    logic [BYTE_W-1:0]  r_ctrl;
    logic [BYTE_W-1:0]  r_store [INFO_BYTES];
    logic               r_out_valid;
    logic               r_frame_ok;
    logic [CODE_W-1:0]  r_error_code;
    logic [BYTE_W-1:0]  r_control_byte;
    logic [INDEX_W-1:0] r_field_index;
    logic [BYTE_W-1:0]  r_field_value;
    logic               r_last;
    logic [ADDR_W-1:0]  w_addr;

    assign w_addr = i_cmd.idx[ADDR_W-1:0];

    assign o_status.start_match = (i_rx_byte == START_BYTE);
    assign o_status.addr_match  = (i_rx_byte == r_dev_addr);
    assign o_status.len_match   = (i_rx_byte == LEN_BYTE);
    assign o_status.stop_match  = (i_rx_byte == STOP_BYTE);
    assign o_status.out_stall   = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= ADDRESS_RESET;
            r_ctrl      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_wdata;
            end
            if (i_cmd.store_ctrl) begin
                r_ctrl <= i_rx_byte;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_info) begin
            r_store[w_addr] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_frame_ok     <= i_cmd.out_ok;
            r_error_code   <= i_cmd.out_code;
            r_control_byte <= i_cmd.out_use_ctrl ? r_ctrl : '0;
            r_field_index  <= i_cmd.idx;
            r_field_value  <= i_cmd.out_from_store ? r_store[w_addr] : '0;
            r_last         <= i_cmd.out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_ok     = r_frame_ok;
    assign o_error_code   = r_error_code;
    assign o_control_byte = r_control_byte;
    assign o_field_index  = r_field_index;
    assign o_field_value  = r_field_value;
    assign o_last         = r_last;

endmodule

/* rtl/sfr_ctrl.sv */
// ----------------------------------------------------------------------------
// sfr_ctrl
// Frame state machine: hunts for the start byte, checks header and stop byte,
// counts information bytes and sequences the result burst or error report.
// ----------------------------------------------------------------------------
module sfr_ctrl
    import sfr_pkg::*;
#(
    parameter int INFO_BYTES = INFO_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADDR = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_CTRL = 3'd3;
    localparam logic [2:0] ST_INFO = 3'd4;
    localparam logic [2:0] ST_STOP = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(INFO_BYTES - 1);

    logic [2:0]         r_state, n_state;
    logic [INDEX_W-1:0] r_count, n_count;
    logic               w_accept;
    t_dp_cmd            w_cmd;

    assign o_in_ready = (r_state != ST_EMIT) && !i_status.out_stall;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_cmd      = w_cmd;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        w_cmd   = '0;
        case (r_state)
            ST_ADDR: begin
                if (w_accept) begin
                    if (i_status.addr_match) begin
                        n_state = ST_LEN;
                    end else begin
                        w_cmd.load_out = 1'b1;
                        w_cmd.out_code = ERR_BAD_ADDR;
                        w_cmd.out_last = 1'b1;
                        n_state        = ST_IDLE;
                        n_count        = '0;
                    end
                end
            end
            ST_LEN: begin
                if (w_accept) begin
                    if (i_status.len_match) begin
                        n_state = ST_CTRL;
                    end else begin
                        w_cmd.load_out = 1'b1;
                        w_cmd.out_code = ERR_BAD_LEN;
                        w_cmd.out_last = 1'b1;
                        n_state        = ST_IDLE;
                        n_count        = '0;
                    end
                end
            end
            ST_CTRL: begin
                if (w_accept) begin
                    w_cmd.store_ctrl = 1'b1;
                    n_count          = '0;
                    n_state          = ST_INFO;
                end
            end
            ST_INFO: begin
                w_cmd.idx = r_count;
                if (w_accept) begin
                    w_cmd.store_info = 1'b1;
                    if (r_count == LAST_IDX) begin
                        n_state = ST_STOP;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ST_STOP: begin
                if (w_accept) begin
                    n_count = '0;
                    if (i_status.stop_match) begin
                        n_state = ST_EMIT;
                    end else begin
                        w_cmd.load_out     = 1'b1;
                        w_cmd.out_code     = ERR_BAD_STOP;
                        w_cmd.out_use_ctrl = 1'b1;
                        w_cmd.out_last     = 1'b1;
                        n_state            = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                w_cmd.idx = r_count;
                if (!i_status.out_stall) begin
                    w_cmd.load_out       = 1'b1;
                    w_cmd.out_ok         = 1'b1;
                    w_cmd.out_code       = ERR_NONE;
                    w_cmd.out_use_ctrl   = 1'b1;
                    w_cmd.out_from_store = 1'b1;
                    w_cmd.out_last       = (r_count == LAST_IDX);
                    if (r_count == LAST_IDX) begin
                        n_state = ST_IDLE;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                if (w_accept) begin
                    n_state = i_status.start_match ? ST_ADDR : ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> !i_status.out_stall)
        else $error("result loaded while output register stalled");

    a_error_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_out && !w_cmd.out_ok) |=> (r_state == ST_IDLE))
        else $error("error report did not return to idle");

    a_emit_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STOP && w_accept && i_status.stop_match)
            |=> (r_state == ST_EMIT && r_count == '0))
        else $error("burst did not start at index zero");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT || r_state == ST_INFO) |-> (r_count <= LAST_IDX))
        else $error("information index out of range");

endmodule

/* rtl/status_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// status_frame_receiver_unit
// Recognizes a status frame in a byte stream and emits its information bytes
// or a single error report.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while no burst runs and no result waits.
// An error report is valid in the cycle after the byte that causes it.
// A good stop byte starts a burst of INFO_BYTES results, loaded from the emit
// state one per cycle as taken; the input stalls during the burst.
// Reset (synchronous, active low) returns to start hunting, empties the output
// and sets the device address to 255.
// ----------------------------------------------------------------------------
module status_frame_receiver_unit
    import sfr_pkg::*;
#(
    parameter int INFO_BYTES = INFO_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] control_byte, [11:8] field_index,
                                        // [19:12] field_value, [23:20] zero
    output logic [2:0]  m_axis_tuser,   // [0] frame_ok, [2:1] error_code
    output logic        m_axis_tlast
);

    t_dp_cmd            w_cmd;
    t_dp_status         w_status;
    logic               w_frame_ok;
    logic [CODE_W-1:0]  w_error_code;
    logic [BYTE_W-1:0]  w_control_byte;
    logic [INDEX_W-1:0] w_field_index;
    logic [BYTE_W-1:0]  w_field_value;

    sfr_ctrl #(
        .INFO_BYTES (INFO_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sfr_datapath #(
        .INFO_BYTES (INFO_BYTES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_byte      (s_axis_tdata),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_frame_ok     (w_frame_ok),
        .o_error_code   (w_error_code),
        .o_control_byte (w_control_byte),
        .o_field_index  (w_field_index),
        .o_field_value  (w_field_value),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_field_value, w_field_index, w_control_byte};
    assign m_axis_tuser = {w_error_code, w_frame_ok};

endmodule
